/* rtl/core/sacc_pkg.sv */
// Shared types and constants of the set-associative LRU cache controller.
package sacc_pkg;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned COUNT_W  = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CACHE_TO_CPU = 3'd0,
    ACT_CPU_TO_CACHE = 3'd1,
    ACT_FILL         = 3'd2,
    ACT_WRITE_BACK   = 3'd3,
    ACT_DISCARD      = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_POS,
    ST_UPD,
    ST_EVICT,
    ST_FILL,
    ST_XFER
  } state_e;

  typedef struct packed {
    action_e             action;
    logic [ADDR_W-1:0]   start_addr;
    logic [COUNT_W-1:0]  word_count;
    logic                last;
  } result_t;

endpackage

/* rtl/core/set_assoc_lru_cache_controller_unit.sv */
// Top level of the set-associative write-back LRU cache tag/policy controller.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid_i/in_stall_o | func_i, addr_i
//   out     | out_valid_o/out_stall_i | action_o, start_addr_o, word_count_o, last_o
//
// An access runs through a set read, a tag scan of one way per cycle and an LRU
// position search of one entry per cycle on a single comparator, then a line update
// and the transfer of its results (1 to 3).
// After reset a clearing pass over all SETS sets initializes the line memory.
// A stalled output holds the sequencer in its result state.
module set_assoc_lru_cache_controller_unit #(
  parameter int unsigned BLOCK_WORDS = 4,
  parameter int unsigned SETS        = 16,
  parameter int unsigned WAYS        = 4,
  parameter int unsigned ADDR_BITS   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [sacc_pkg::ADDR_W-1:0]    addr_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sacc_pkg::ACTION_W-1:0]  action_o,
  output logic [sacc_pkg::ADDR_W-1:0]    start_addr_o,
  output logic [sacc_pkg::COUNT_W-1:0]   word_count_o,
  output logic                           last_o
);

  localparam int unsigned TW = ADDR_BITS - $clog2(BLOCK_WORDS) - $clog2(SETS);
  localparam int unsigned WB = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned RW = WAYS * (2 + TW + WB);

  logic              ram_we, ram_re, res_ld, res_free;
  logic [SW-1:0]     ram_waddr, ram_raddr;
  logic [RW-1:0]     ram_wdata, ram_rdata;
  sacc_pkg::result_t res, res_out;

  sacc_tag_ram #(
    .DEPTH (SETS),
    .WIDTH (RW),
    .IDX_W (SW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sacc_ctrl #(
    .BLOCK_WORDS (BLOCK_WORDS),
    .SETS        (SETS),
    .WAYS        (WAYS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .addr_i      (addr_i),
    .in_stall_o  (in_stall_o),
    .row_i       (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .res_ld_o    (res_ld),
    .res_o       (res),
    .res_free_i  (res_free)
  );

  sacc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (res_ld),
    .res_i       (res),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign action_o     = res_out.action;
  assign start_addr_o = res_out.start_addr;
  assign word_count_o = res_out.word_count;
  assign last_o       = res_out.last;

endmodule

/* rtl/core/sacc_tag_ram.sv */
// Set-indexed line state memory: one write port, one registered read port.
module sacc_tag_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sacc_ctrl.sv */
// Access sequencer: way scan and LRU search on one shared comparator, line update, result issue.
module sacc_ctrl #(
  parameter int unsigned BLOCK_WORDS = 4,
  parameter int unsigned SETS        = 16,
  parameter int unsigned WAYS        = 4,
  parameter int unsigned ADDR_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         func_i,
  input  logic [sacc_pkg::ADDR_W-1:0]  addr_i,
  output logic                         in_stall_o,
  input  logic [WAYS*(2+ADDR_BITS-$clog2(BLOCK_WORDS)-$clog2(SETS)
                      +((WAYS > 1) ? $clog2(WAYS) : 1))-1:0] row_i,
  output logic                         ram_we_o,
  output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] ram_waddr_o,
  output logic [WAYS*(2+ADDR_BITS-$clog2(BLOCK_WORDS)-$clog2(SETS)
                      +((WAYS > 1) ? $clog2(WAYS) : 1))-1:0] ram_wdata_o,
  output logic                         ram_re_o,
  output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] ram_raddr_o,
  output logic                         res_ld_o,
  output sacc_pkg::result_t            res_o,
  input  logic                         res_free_i
);

  localparam int unsigned OB     = $clog2(BLOCK_WORDS);
  localparam int unsigned SB     = $clog2(SETS);
  localparam int unsigned TSHIFT = OB + SB;
  localparam int unsigned TW     = ADDR_BITS - TSHIFT;
  localparam int unsigned WB     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SW     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned EW     = 2 + TW + WB;
  localparam int unsigned RW     = WAYS * EW;
  localparam int unsigned AW     = ADDR_BITS;
  localparam int unsigned OW     = sacc_pkg::ADDR_W;
  localparam int unsigned CNW    = sacc_pkg::COUNT_W;
  localparam int unsigned CW     = (TW > WB) ? TW : WB;

  sacc_pkg::state_e state_q, state_d;
  logic          wr_q, wr_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [WB-1:0] idx_q, idx_d;
  logic [WB-1:0] way_q, way_d;
  logic [WB-1:0] pos_q, pos_d;
  logic          hit_q, hit_d;
  logic [SW-1:0] clr_q, clr_d;

  logic [SW-1:0] set_idx;
  logic [TW-1:0] tag;
  logic [CW-1:0] cmp_a, cmp_b;
  logic          cmp_eq;
  logic [EW-1:0] cur_ent, vic_ent;
  logic [RW-1:0] upd_row, clr_row;

  assign set_idx = SW'(addr_q >> OB) & SW'(SETS - 1);
  assign tag     = TW'(addr_q >> TSHIFT);
  assign cur_ent = row_i[idx_q*EW +: EW];
  assign vic_ent = row_i[way_q*EW +: EW];

  // shared comparator: tag match during scan, LRU position search afterwards
  always_comb begin
    if (state_q == sacc_pkg::ST_SCAN) begin
      cmp_a = CW'(cur_ent[WB +: TW]);
      cmp_b = CW'(tag);
    end else begin
      cmp_a = CW'(cur_ent[0 +: WB]);
      cmp_b = CW'(way_q);
    end
  end
  assign cmp_eq = (cmp_a == cmp_b);

  always_comb begin
    logic [EW-1:0] ent;
    upd_row = row_i;
    clr_row = '0;
    for (int w = 0; w < WAYS; w++) begin
      ent = row_i[w*EW +: EW];
      if (WB'(w) == way_q) begin
        ent[EW-1] = 1'b1;
        ent[EW-2] = hit_q ? (ent[EW-2] | wr_q) : wr_q;
        if (!hit_q) begin
          ent[WB +: TW] = tag;
        end
      end
      if (w == WAYS - 1) begin
        ent[0 +: WB] = way_q;
      end else if (WB'(w) >= pos_q) begin
        ent[0 +: WB] = row_i[(w+1)*EW +: WB];
      end
      upd_row[w*EW +: EW] = ent;
      clr_row[w*EW +: WB] = WB'(w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sacc_pkg::ST_CLEAR;
      clr_q   <= '0;
      idx_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q   <= wr_d;
    addr_q <= addr_d;
    way_q  <= way_d;
    pos_q  <= pos_d;
  end

  always_comb begin
    state_d     = state_q;
    wr_d        = wr_q;
    addr_d      = addr_q;
    idx_d       = idx_q;
    way_d       = way_q;
    pos_d       = pos_q;
    hit_d       = hit_q;
    clr_d       = clr_q;
    in_stall_o  = 1'b1;
    ram_we_o    = 1'b0;
    ram_waddr_o = set_idx;
    ram_wdata_o = upd_row;
    ram_re_o    = 1'b0;
    ram_raddr_o = set_idx;
    res_ld_o    = 1'b0;
    res_o.action     = sacc_pkg::ACT_CACHE_TO_CPU;
    res_o.start_addr = OW'(addr_q);
    res_o.word_count = CNW'(1);
    res_o.last       = 1'b1;
    unique case (state_q)
      sacc_pkg::ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = clr_row;
        clr_d       = clr_q + SW'(1);
        if (clr_q == SW'(SETS - 1)) begin
          state_d = sacc_pkg::ST_IDLE;
        end
      end
      sacc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          wr_d    = func_i;
          addr_d  = AW'(addr_i);
          state_d = sacc_pkg::ST_READ;
        end
      end
      sacc_pkg::ST_READ: begin
        ram_re_o = 1'b1;
        idx_d    = '0;
        hit_d    = 1'b0;
        state_d  = sacc_pkg::ST_SCAN;
      end
      sacc_pkg::ST_SCAN: begin
        if (cur_ent[EW-1] && cmp_eq) begin
          hit_d   = 1'b1;
          way_d   = idx_q;
          idx_d   = '0;
          state_d = sacc_pkg::ST_POS;
        end else if (idx_q == WB'(WAYS - 1)) begin
          way_d   = row_i[0 +: WB];
          idx_d   = '0;
          state_d = sacc_pkg::ST_POS;
        end else begin
          idx_d = idx_q + WB'(1);
        end
      end
      sacc_pkg::ST_POS: begin
        if (cmp_eq || idx_q == WB'(WAYS - 1)) begin
          pos_d   = idx_q;
          state_d = sacc_pkg::ST_UPD;
        end else begin
          idx_d = idx_q + WB'(1);
        end
      end
      sacc_pkg::ST_UPD: begin
        ram_we_o = 1'b1;
        if (hit_q) begin
          state_d = sacc_pkg::ST_XFER;
        end else if (vic_ent[EW-1]) begin
          state_d = sacc_pkg::ST_EVICT;
        end else begin
          state_d = sacc_pkg::ST_FILL;
        end
      end
      sacc_pkg::ST_EVICT: begin
        res_o.action     = vic_ent[EW-2] ? sacc_pkg::ACT_WRITE_BACK : sacc_pkg::ACT_DISCARD;
        res_o.start_addr = OW'((AW'(vic_ent[WB +: TW]) << TSHIFT) | (AW'(set_idx) << OB));
        res_o.word_count = CNW'(BLOCK_WORDS);
        res_o.last       = 1'b0;
        if (res_free_i) begin
          res_ld_o = 1'b1;
          state_d  = sacc_pkg::ST_FILL;
        end
      end
      sacc_pkg::ST_FILL: begin
        res_o.action     = sacc_pkg::ACT_FILL;
        res_o.start_addr = OW'((addr_q >> OB) << OB);
        res_o.word_count = CNW'(BLOCK_WORDS);
        res_o.last       = 1'b0;
        if (res_free_i) begin
          res_ld_o = 1'b1;
          state_d  = sacc_pkg::ST_XFER;
        end
      end
      sacc_pkg::ST_XFER: begin
        res_o.action = wr_q ? sacc_pkg::ACT_CPU_TO_CACHE : sacc_pkg::ACT_CACHE_TO_CPU;
        if (res_free_i) begin
          res_ld_o = 1'b1;
          state_d  = sacc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sacc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/sacc_out_reg.sv */
// Result output register with valid/stall handshake.
module sacc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ld_i,
  input  sacc_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sacc_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  sacc_pkg::result_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ld_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* tb/set_assoc_lru_cache_controller_unit_test.sv */
// Testbench of the set-associative LRU cache controller: directed and random traffic checked against a predictor.
module set_assoc_lru_cache_controller_unit_test;

  localparam int unsigned ADDR_W    = sacc_pkg::ADDR_W;
  localparam int unsigned ACTION_W  = sacc_pkg::ACTION_W;
  localparam int unsigned COUNT_W   = sacc_pkg::COUNT_W;
  localparam int unsigned BLK_WORDS = 4;
  localparam int unsigned N_SETS    = 16;
  localparam int unsigned N_WAYS    = 4;
  localparam int unsigned OFS_BITS  = 2;
  localparam int unsigned SET_BITS  = 4;
  localparam int unsigned TAG_W     = ADDR_W - OFS_BITS - SET_BITS;
  localparam int unsigned N_LINES   = N_SETS * N_WAYS;
  localparam int unsigned MAX_CYCLES = 200000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  localparam logic FN_READ  = 1'b0;
  localparam logic FN_WRITE = 1'b1;

  typedef struct {
    logic              func;
    logic [ADDR_W-1:0] addr;
    int unsigned       gap;
  } access_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                func_i;
  logic [ADDR_W-1:0]   addr_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ACTION_W-1:0] action_o;
  logic [ADDR_W-1:0]   start_addr_o;
  logic [COUNT_W-1:0]  word_count_o;
  logic                last_o;

  // predicted cache state
  logic             ln_valid[N_LINES];
  logic             ln_dirty[N_LINES];
  logic [TAG_W-1:0] ln_tag[N_LINES];
  logic [1:0]       lru_pos[N_LINES];

  access_t           access_q[$];
  sacc_pkg::result_t expected_q[$];
  access_t           next_access;
  sacc_pkg::result_t exp_r;
  logic              in_acc;
  logic              out_acc;
  int unsigned       accesses_taken;
  int unsigned       results_seen;
  int unsigned       err_cnt;
  int unsigned       idle_left;
  bit                gap_loaded;
  int unsigned       wait_left;
  int unsigned       hold_left;
  logic              hold_done;
  logic              long_hold;
  int unsigned       cycle_cnt;

  set_assoc_lru_cache_controller_unit #(
    .BLOCK_WORDS(BLK_WORDS),
    .SETS       (N_SETS),
    .WAYS       (N_WAYS),
    .ADDR_BITS  (ADDR_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .addr_i      (addr_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .action_o    (action_o),
    .start_addr_o(start_addr_o),
    .word_count_o(word_count_o),
    .last_o      (last_o)
  );

  function automatic void predict_access(input logic wr, input logic [ADDR_W-1:0] a);
    int unsigned set_idx;
    int unsigned base;
    int unsigned way;
    logic [TAG_W-1:0] tg;
    bit hit;
    bit moved;
    sacc_pkg::result_t r;
    set_idx = 32'(a[OFS_BITS +: SET_BITS]);
    tg = a[ADDR_W-1 -: TAG_W];
    base = set_idx * N_WAYS;
    hit = 0;
    moved = 0;
    way = 0;
    for (int i = 0; i < N_WAYS; i++) begin
      if (!hit && ln_valid[base+i] && ln_tag[base+i] == tg) begin
        hit = 1;
        way = i;
      end
    end
    if (!hit) begin
      way = 32'(lru_pos[base]);
      if (ln_valid[base+way]) begin
        r.action = ln_dirty[base+way] ? sacc_pkg::ACT_WRITE_BACK : sacc_pkg::ACT_DISCARD;
        r.start_addr = {ln_tag[base+way], set_idx[SET_BITS-1:0], {OFS_BITS{1'b0}}};
        r.word_count = COUNT_W'(BLK_WORDS);
        r.last = 1'b0;
        expected_q.push_back(r);
      end
      ln_valid[base+way] = 1'b1;
      ln_dirty[base+way] = 1'b0;
      ln_tag[base+way] = tg;
      r.action = sacc_pkg::ACT_FILL;
      r.start_addr = {a[ADDR_W-1:OFS_BITS], {OFS_BITS{1'b0}}};
      r.word_count = COUNT_W'(BLK_WORDS);
      r.last = 1'b0;
      expected_q.push_back(r);
    end
    if (wr) ln_dirty[base+way] = 1'b1;
    r.action = wr ? sacc_pkg::ACT_CPU_TO_CACHE : sacc_pkg::ACT_CACHE_TO_CPU;
    r.start_addr = a;
    r.word_count = COUNT_W'(1);
    r.last = 1'b1;
    expected_q.push_back(r);
    // move the accessed way to the most recently used position
    for (int p = 0; p < N_WAYS; p++) begin
      if (!moved && lru_pos[base+p] == way) begin
        for (int q = p; q + 1 < N_WAYS; q++) lru_pos[base+q] = lru_pos[base+q+1];
        lru_pos[base+N_WAYS-1] = 2'(way);
        moved = 1;
      end
    end
  endfunction

  function automatic void push_access(input logic f, input logic [ADDR_W-1:0] a,
                                      input int unsigned gap);
    access_t it;
    it.func = f;
    it.addr = a;
    it.gap = gap;
    access_q.push_back(it);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // transfer driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && !in_acc)) begin
        if (!gap_loaded && access_q.size() != 0) begin
          idle_left = access_q[0].gap;
          gap_loaded = 1;
        end
        if (idle_left != 0) begin
          idle_left--;
          in_valid_i <= 1'b0;
        end else if (access_q.size() != 0) begin
          next_access = access_q.pop_front();
          func_i <= next_access.func;
          addr_i <= next_access.addr;
          in_valid_i <= 1'b1;
          gap_loaded = 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_acc) begin
        wait_left = (results_seen >= 150 && results_seen < 250) ? 0 : $urandom_range(0, 11);
      end else if (wait_left != 0) begin
        wait_left--;
      end
      out_stall_i <= long_hold || (wait_left != 0);
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
      long_hold <= 1'b0;
    end else if (!hold_done && accesses_taken >= 40) begin
      hold_left <= LONG_HOLD_CYCLES;
      hold_done <= 1'b1;
      long_hold <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else begin
      hold_left <= 0;
      long_hold <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_acc <= 1'b0;
      out_acc <= 1'b0;
      accesses_taken <= 0;
      results_seen <= 0;
    end else begin
      in_acc <= in_valid_i && !in_stall_o;
      out_acc <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o) begin
        predict_access(func_i, addr_i);
        accesses_taken <= accesses_taken + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: action %0d addr %h count %0d last %0d",
                     action_o, start_addr_o, word_count_o, last_o);
        end else begin
          exp_r = expected_q.pop_front();
          if (action_o !== exp_r.action || start_addr_o !== exp_r.start_addr ||
              word_count_o !== exp_r.word_count || last_o !== exp_r.last) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"mismatch: expected action %0d addr %h count %0d last %0d,",
                        " got %0d %h %0d %0d"},
                       exp_r.action, exp_r.start_addr, exp_r.word_count, exp_r.last,
                       action_o, start_addr_o, word_count_o, last_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned tg;
    int unsigned st;
    int unsigned gap;
    int unsigned tag_pool[6];
    logic [ADDR_W-1:0] a;
    tag_pool = '{0, 1, 2, 3, 10'h3FF, 10'h2AA};
    err_cnt = 0;
    cycle_cnt = 0;
    idle_left = 0;
    gap_loaded = 0;
    wait_left = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = FN_READ;
    addr_i = '0;
    out_stall_i = 1'b0;
    for (int i = 0; i < N_LINES; i++) begin
      ln_valid[i] = 1'b0;
      ln_dirty[i] = 1'b0;
      ln_tag[i] = '0;
      lru_pos[i] = 2'(i % N_WAYS);
    end

    // directed: extremes, hits, write-back and discard evictions
    push_access(FN_READ,  16'h0000, $urandom_range(0, 11));
    push_access(FN_WRITE, 16'h0000, $urandom_range(0, 11));
    push_access(FN_READ,  16'hFFFF, $urandom_range(0, 11));
    push_access(FN_WRITE, 16'hFFFF, $urandom_range(0, 11));
    push_access(FN_WRITE, 16'h0040, $urandom_range(0, 11));
    push_access(FN_READ,  16'h0081, $urandom_range(0, 11));
    push_access(FN_READ,  16'h00C2, $urandom_range(0, 11));
    push_access(FN_READ,  16'h0103, 0);
    push_access(FN_READ,  16'h0140, 0);
    push_access(FN_READ,  16'h0180, 0);
    push_access(FN_READ,  16'h0103, $urandom_range(0, 11));
    push_access(FN_WRITE, 16'h01C0, $urandom_range(0, 11));
    push_access(FN_READ,  16'h0000, $urandom_range(0, 11));
    push_access(FN_READ,  16'h0140, $urandom_range(0, 11));
    push_access(FN_WRITE, 16'h8000, $urandom_range(0, 11));
    push_access(FN_WRITE, 16'h4000, $urandom_range(0, 11));
    push_access(FN_READ,  16'hAAAA, $urandom_range(0, 11));
    push_access(FN_WRITE, 16'h5555, $urandom_range(0, 11));
    push_access(FN_READ,  16'hFFC0, $urandom_range(0, 11));
    push_access(FN_READ,  16'h7FFF, $urandom_range(0, 11));

    // random: mostly a small tag pool on few sets to force hits and evictions
    for (int k = 0; k < 250; k++) begin
      gap = (k >= 60 && k < 100) ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 9) < 7) begin
        tg = tag_pool[$urandom_range(0, 5)];
        st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, N_SETS - 1) : $urandom_range(0, 2);
        a = {tg[TAG_W-1:0], st[SET_BITS-1:0], OFS_BITS'($urandom_range(0, BLK_WORDS - 1))};
      end else begin
        a = ADDR_W'($urandom_range(0, 16'hFFFF));
      end
      push_access($urandom_range(0, 1) ? FN_WRITE : FN_READ, a, gap);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (access_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
